FILE: sv/ook_pulse_word_receiver_defines.svh
// ----------------------------------------------------------------------------
// ook_pulse_word_receiver_defines.svh
// Assertion helper macros shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_WORD_RECEIVER_DEFINES_SVH
`define OOK_PULSE_WORD_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OPWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OPWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/opwr_pkg.sv
// ----------------------------------------------------------------------------
// opwr_pkg
// Constants and types for the OOK pulse word receiver.
// ----------------------------------------------------------------------------
package opwr_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int CMP_W     = (WORD_BITS > 32) ? WORD_BITS : 32;

  localparam logic [31:0] UPPER_HALF_MASK = 32'hFFFF_0000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STATION_ID = 3'd0,
    REG_SHORT_MIN  = 3'd1,
    REG_SHORT_MAX  = 3'd2,
    REG_HB_REFRESH = 3'd3,
    REG_ALARM_TICKS = 3'd4
  } cfg_reg_t;

  // Input kind carried on tuser
  typedef enum logic {
    CMD_PULSE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // Reset values of the configuration registers
  localparam logic [31:0] STATION_ID_RST  = 32'h0000_0000;
  localparam logic [7:0]  SHORT_MIN_RST   = 8'h02;
  localparam logic [7:0]  SHORT_MAX_RST   = 8'h0E;
  localparam logic [2:0]  HB_REFRESH_RST  = 3'd4;
  localparam logic [7:0]  ALARM_TICKS_RST = 8'd15;
  localparam logic [2:0]  HB_COUNT_RST    = 3'd4;

  // Result flags, highest bit first, as laid out on out_tuser
  typedef struct packed {
    logic out_of_range_alarm;
    logic screen_refresh;
    logic heartbeat_seen;
    logic call_alert;
    logic word_done;
  } result_flags_t;

endpackage

FILE: sv/ook_pulse_word_receiver.sv
// ----------------------------------------------------------------------------
// ook_pulse_word_receiver
// Pulse-width OOK bit slicer that assembles words and matches station address.
// A beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_tready is high; the single update stage sets the rate.
// Reset: synchronous, active low; clears state and loads register defaults.
// ----------------------------------------------------------------------------
`include "ook_pulse_word_receiver_defines.svh"

module ook_pulse_word_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pulse_width
  input  logic        in_tuser,   // [0] command (0 pulse, 1 tick)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] received_word
  output logic [4:0]  out_tuser,  // [0] word_done [1] call_alert [2] heartbeat_seen
                                  // [3] screen_refresh [4] out_of_range_alarm
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int W  = opwr_pkg::WORD_BITS;
  localparam int CW = opwr_pkg::CNT_W;
  localparam int MW = opwr_pkg::CMP_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user must write only while
  // the pipe is empty (the block itself does not enforce this), so no ordering against beats is needed.
  // --------------------------------------------------------------------------
  logic [31:0] station_id_r;
  logic [7:0]  short_min_r;
  logic [7:0]  short_max_r;
  logic [2:0]  hb_refresh_r;
  logic [7:0]  alarm_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_id_r  <= opwr_pkg::STATION_ID_RST;
      short_min_r   <= opwr_pkg::SHORT_MIN_RST;
      short_max_r   <= opwr_pkg::SHORT_MAX_RST;
      hb_refresh_r  <= opwr_pkg::HB_REFRESH_RST;
      alarm_ticks_r <= opwr_pkg::ALARM_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        opwr_pkg::REG_STATION_ID:  station_id_r  <= cfg_data;
        opwr_pkg::REG_SHORT_MIN:   short_min_r   <= cfg_data[7:0];
        opwr_pkg::REG_SHORT_MAX:   short_max_r   <= cfg_data[7:0];
        opwr_pkg::REG_HB_REFRESH:  hb_refresh_r  <= cfg_data[2:0];
        opwr_pkg::REG_ALARM_TICKS: alarm_ticks_r <= cfg_data[7:0];
        default: ;  // unmapped index: write is dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control. Stage 1 is the input register, stage 2 the result register.
  // Stage 1 moves on whenever the result register is empty or being drained.
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_width_r;
  logic       out_valid_r;
  logic       advance;
  logic       s1_fire;

  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= in_tuser;
      s1_width_r <= in_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Update logic. The word is built as a left shift register, MSB first;
  // a pulse inside the short window shifts in a one.
  // --------------------------------------------------------------------------
  logic [W-1:0]  word_r,      word_nxt;
  logic [CW-1:0] bit_cnt_r,   bit_cnt_nxt;
  logic [2:0]    hb_count_r,  hb_count_nxt;
  logic [7:0]    tick_cnt_r,  tick_cnt_nxt;

  logic          is_tick;
  logic          bit_one;
  logic [W-1:0]  shifted;
  logic          last_bit;
  logic [MW-1:0] word_ext;
  logic [2:0]    hb_dec;
  logic [7:0]    tick_inc;
  opwr_pkg::result_flags_t flags;
  logic [31:0]   word_out;

  always_comb begin
    is_tick  = (s1_cmd_r == opwr_pkg::CMD_TICK);
    bit_one  = (s1_width_r >= short_min_r) && (s1_width_r <= short_max_r);
    shifted  = {word_r[W-2:0], bit_one};
    last_bit = (bit_cnt_r == CW'(W - 1));
    word_ext = MW'(shifted);
    hb_dec   = hb_count_r - 3'd1;
    tick_inc = tick_cnt_r + 8'd1;

    word_nxt     = word_r;
    bit_cnt_nxt  = bit_cnt_r;
    hb_count_nxt = hb_count_r;
    tick_cnt_nxt = tick_cnt_r;
    flags        = '0;
    word_out     = '0;

    if (is_tick) begin
      tick_cnt_nxt             = tick_inc;
      flags.out_of_range_alarm = (tick_inc == alarm_ticks_r);
    end else if (last_bit) begin
      word_nxt        = '0;
      bit_cnt_nxt     = '0;
      flags.word_done = 1'b1;
      word_out        = word_ext[31:0];
      if (word_ext == MW'(station_id_r)) begin
        flags.call_alert = 1'b1;
      end else if (word_ext == MW'(station_id_r & opwr_pkg::UPPER_HALF_MASK)) begin
        // heartbeat: restart the silence timer and step the refresh divider
        flags.heartbeat_seen = 1'b1;
        tick_cnt_nxt         = '0;
        if (hb_dec == 3'd0) begin
          hb_count_nxt         = hb_refresh_r;
          flags.screen_refresh = 1'b1;
        end else begin
          hb_count_nxt = hb_dec;
        end
      end
    end else begin
      word_nxt    = shifted;
      bit_cnt_nxt = bit_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r     <= '0;
      bit_cnt_r  <= '0;
      hb_count_r <= opwr_pkg::HB_COUNT_RST;
      tick_cnt_r <= '0;
    end else if (s1_fire) begin
      word_r     <= word_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      hb_count_r <= hb_count_nxt;
      tick_cnt_r <= tick_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [31:0]             out_word_r;
  opwr_pkg::result_flags_t out_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r  <= word_out;
      out_flags_r <= flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = {out_flags_r.out_of_range_alarm, out_flags_r.screen_refresh,
                       out_flags_r.heartbeat_seen, out_flags_r.call_alert,
                       out_flags_r.word_done};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `OPWR_ASSERT_NOW(a_word_zero_unless_done,
    out_valid_r && !out_flags_r.word_done, out_word_r == 32'd0,
    "received_word nonzero without word_done")
  `OPWR_ASSERT_NOW(a_match_exclusive,
    out_valid_r && out_flags_r.call_alert, !out_flags_r.heartbeat_seen,
    "call_alert and heartbeat_seen both set")
  `OPWR_ASSERT_NOW(a_refresh_needs_heartbeat,
    out_valid_r && out_flags_r.screen_refresh, out_flags_r.heartbeat_seen,
    "screen_refresh without heartbeat")
  `OPWR_ASSERT_NOW(a_alarm_only_on_tick,
    out_valid_r && out_flags_r.out_of_range_alarm, !out_flags_r.word_done,
    "alarm raised on a pulse beat")
  `OPWR_ASSERT_NEXT(a_count_restarts,
    s1_fire && !is_tick && last_bit, bit_cnt_r == '0 && word_r == '0,
    "bit counter not cleared after word")

endmodule

FILE: tb/ook_pulse_word_receiver_tb.sv
// ----------------------------------------------------------------------------
// ook_pulse_word_receiver_tb
// Self-checking bench for the OOK pulse word receiver. Pulse and tick beats
// are queued and fed by a clocked driver. Each accepted beat updates a local
// bit slicer / address matcher, which queues the result it should cause. A
// clocked monitor compares every result beat with the oldest queued result.
// Phases cover several register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_pulse_word_receiver_tb;
  import opwr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 4;     // margin past the input and result registers

  // widths around the reset window [2, 14] plus the field extremes
  localparam logic [7:0] PROBE_WIDTHS [9] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd13,
                                              8'd14, 8'd15, 8'd128, 8'd255};

  typedef struct packed {
    logic [31:0]   word;
    result_flags_t flags;
  } rx_result_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] width;
  } rx_beat_t;

  // DUT ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] pulse_width
  logic        in_tuser   = 1'b0;   // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] received_word
  logic [4:0]  out_tuser;           // [0] word_done .. [4] out_of_range_alarm
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic [31:0] cfg_data   = 32'd0;

  ook_pulse_word_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the receiver: registers and state
  // --------------------------------------------------------------------------
  logic [31:0]          own_addr    = STATION_ID_RST;
  logic [7:0]           win_lo      = SHORT_MIN_RST;
  logic [7:0]           win_hi      = SHORT_MAX_RST;
  logic [2:0]           hb_interval = HB_REFRESH_RST;
  logic [7:0]           alarm_lim   = ALARM_TICKS_RST;

  logic [WORD_BITS-1:0] inv_word    = '1;  // complement of the word being built
  int unsigned          bit_pos     = 0;
  logic [2:0]           hb_left     = HB_COUNT_RST;
  logic [7:0]           tick_cnt    = 8'd0;

  // Bench bookkeeping
  rx_beat_t      pend_q [$];     // beats waiting for the driver
  rx_result_t    result_q [$];   // results owed by the block, oldest first
  rx_result_t    want;
  result_flags_t got_flags;
  int            n_queued      = 0;
  int            n_checked     = 0;
  int            n_errors      = 0;
  int            gen_pos       = 0;  // pulses queued, mod WORD_BITS
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            in_taken      = 1'b0;
  bit            hold_start    = 1'b0;
  int            hold_left     = 0;
  int            cycle_cnt     = 0;

  // One beat through the slicer/matcher; returns the result it causes.
  function automatic rx_result_t slice_and_match(cmd_t cmd, logic [7:0] width);
    rx_result_t           r;
    logic [WORD_BITS-1:0] word;
    r = '0;
    if (cmd == CMD_TICK) begin
      tick_cnt = tick_cnt + 8'd1;  // wraps 255 -> 0
      r.flags.out_of_range_alarm = (tick_cnt == alarm_lim);
      return r;
    end
    if (bit_pos >= WORD_BITS) bit_pos = 0;
    // in-window width is a one bit, MSB first; empty window never matches
    if (width >= win_lo && width <= win_hi) inv_word[WORD_BITS-1-bit_pos] = 1'b0;
    bit_pos++;
    if (bit_pos == WORD_BITS) begin
      word     = ~inv_word;
      bit_pos  = 0;
      inv_word = '1;
      r.flags.word_done = 1'b1;
      r.word = word[31:0];
      // full match wins over the upper-half match
      if (word == own_addr) begin
        r.flags.call_alert = 1'b1;
      end else if (word == (own_addr & UPPER_HALF_MASK)) begin
        r.flags.heartbeat_seen = 1'b1;
        tick_cnt = 8'd0;
        hb_left  = hb_left - 3'd1;  // 3-bit down counter, interval 0 acts as 8
        if (hb_left == 3'd0) begin
          hb_left = hb_interval;
          r.flags.screen_refresh = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_beat(cmd_t cmd, logic [7:0] width);
    rx_beat_t b;
    b.cmd   = cmd;
    b.width = width;
    pend_q.push_back(b);
    n_queued++;
    if (cmd == CMD_PULSE) gen_pos = (gen_pos + 1) % WORD_BITS;
  endtask

  // Pick a width that the current window decodes as the wanted bit.
  function automatic logic [7:0] width_for(bit one);
    bit has_below;
    bit has_above;
    if (win_lo > win_hi) return 8'($urandom_range(255, 0));  // all zeros anyway
    if (one) return 8'($urandom_range(win_hi, win_lo));
    has_below = (win_lo != 8'd0);
    has_above = (win_hi != 8'hFF);
    if (has_below && (!has_above || $urandom_range(1) == 0))
      return 8'($urandom_range(win_lo - 1, 0));
    if (has_above) return 8'($urandom_range(255, win_hi + 1));
    return 8'($urandom_range(255, 0));  // window covers all widths: no zero bit
  endfunction

  // Aligned word: finish the partial word with noise, then 32 coded pulses
  // with the odd tick mixed in.
  task automatic queue_word(logic [31:0] target);
    while (gen_pos != 0) queue_beat(CMD_PULSE, 8'($urandom));
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if ($urandom_range(9) == 0) queue_beat(CMD_TICK, 8'($urandom));
      queue_beat(CMD_PULSE, width_for(target[i]));
    end
  endtask

  task automatic queue_random(int n_items);
    int stop;
    int pick;
    stop = n_queued + n_items;
    while (n_queued < stop) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2: queue_word(own_addr);
        3, 4:    queue_word(own_addr & UPPER_HALF_MASK);
        5:       queue_word(own_addr ^ (32'd1 << $urandom_range(31)));  // near miss
        6:       queue_word($urandom);
        default: begin
          repeat ($urandom_range(6, 1))
            queue_beat(($urandom_range(3) == 0) ? CMD_TICK : CMD_PULSE, 8'($urandom));
        end
      endcase
    end
  endtask

  // Register write; unused upper data bits carry junk.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    logic [31:0] bus;
    case (idx)
      REG_STATION_ID: bus = value;
      REG_HB_REFRESH: bus = {29'($urandom), value[2:0]};
      default:        bus = {24'($urandom), value[7:0]};
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bus;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STATION_ID:  own_addr    = bus;
      REG_SHORT_MIN:   win_lo      = bus[7:0];
      REG_SHORT_MAX:   win_hi      = bus[7:0];
      REG_HB_REFRESH:  hb_interval = bus[2:0];
      REG_ALARM_TICKS: alarm_lim   = bus[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every beat owes exactly one result, so counts tell when the block is idle.
  task automatic wait_drained;
    @(negedge clk);
    while (n_checked != n_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int n_items);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    queue_random(n_items);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds a beat until taken, then offers the next one or idles
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_beat_t b;
    if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= b.width;
        in_tuser  <= b.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input beat, check each result beat
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(slice_and_match(cmd_t'(in_tuser), in_tdata));
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: tdata 0x%0h tuser 0x%0h",
                 out_tdata, out_tuser);
          n_errors++;
        end else begin
          want      = result_q.pop_front();
          got_flags = result_flags_t'(out_tuser);
          compare_field("received_word", want.word, out_tdata);
          compare_field("word_done", want.flags.word_done, got_flags.word_done);
          compare_field("call_alert", want.flags.call_alert, got_flags.call_alert);
          compare_field("heartbeat_seen", want.flags.heartbeat_seen,
                        got_flags.heartbeat_seen);
          compare_field("screen_refresh", want.flags.screen_refresh,
                        got_flags.screen_refresh);
          compare_field("out_of_range_alarm", want.flags.out_of_range_alarm,
                        got_flags.out_of_range_alarm);
          n_checked++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int lo;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: window edges and width extremes at reset settings, both kinds
    foreach (PROBE_WIDTHS[i]) queue_beat(CMD_PULSE, PROBE_WIDTHS[i]);
    queue_beat(CMD_TICK, 8'h00);
    queue_beat(CMD_TICK, 8'hFF);
    wait_drained();

    // Address with zero lower half: a full match must not count as heartbeat.
    // No idling, except one long receiver hold-off while the sender keeps going.
    write_reg(REG_STATION_ID, 32'h1234_0000);
    write_reg(REG_SHORT_MIN, 8'd3);
    write_reg(REG_SHORT_MAX, 8'd10);
    write_reg(REG_HB_REFRESH, 3'd1);
    write_reg(REG_ALARM_TICKS, 8'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_start = 1'b1;
    queue_random(30);
    wait_drained();

    // Window covers every width: all bits one, all-ones address
    write_reg(REG_STATION_ID, 32'hFFFF_FFFF);
    write_reg(REG_SHORT_MIN, 8'd0);
    write_reg(REG_SHORT_MAX, 8'd255);
    write_reg(REG_HB_REFRESH, 3'd7);
    write_reg(REG_ALARM_TICKS, 8'd8);
    run_phase(56, 0, 25);

    // Empty window: every word is zero, which is a heartbeat for an address
    // with zero upper half; refresh interval 0 runs as 8
    write_reg(REG_STATION_ID, {16'h0000, 16'($urandom_range(65535, 1))});
    write_reg(REG_SHORT_MIN, 8'd200);
    write_reg(REG_SHORT_MAX, 8'd100);
    write_reg(REG_HB_REFRESH, 3'd0);
    write_reg(REG_ALARM_TICKS, 8'd1);
    run_phase(0, 56, 80);

    // Tick counter: alarm at 255, then alarm 0 on the wrap to zero
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_ALARM_TICKS, 8'd255);
    repeat (255 - int'(tick_cnt)) queue_beat(CMD_TICK, 8'($urandom));
    wait_drained();
    write_reg(REG_ALARM_TICKS, 8'd0);
    queue_beat(CMD_TICK, 8'($urandom));
    queue_beat(CMD_TICK, 8'($urandom));
    wait_drained();

    // Random address and window, both sides idling
    lo = $urandom_range(100, 0);
    write_reg(REG_STATION_ID, $urandom);
    write_reg(REG_SHORT_MIN, 8'(lo));
    write_reg(REG_SHORT_MAX, 8'(lo + $urandom_range(60, 0)));
    write_reg(REG_HB_REFRESH, 3'd2);
    write_reg(REG_ALARM_TICKS, 8'($urandom_range(8, 2)));
    run_phase(26, 26, 30);

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/opwr_pkg.sv
sv/ook_pulse_word_receiver.sv
tb/ook_pulse_word_receiver_tb.sv
